>>> hw/rtl/pid_motor_position_axis_defines.svh
// Assertion macros of the motor position axis RTL.
`ifndef PID_MOTOR_POSITION_AXIS_DEFINES_SVH
`define PID_MOTOR_POSITION_AXIS_DEFINES_SVH

// Same-cycle implication, checked on aclk outside of reset.
`define PMPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside of reset.
`define PMPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pmpa_pkg.sv
// Shared types and constants of the motor position axis.
`timescale 1ns / 1ps

package pmpa_pkg;

    localparam int GAIN_W   = 16;
    localparam int TARGET_W = 17;
    localparam int POS_W    = 32;
    localparam int DRIVE_W  = 8;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Command codes of an input item.
    localparam logic [1:0] CMD_EDGE = 2'd0;
    localparam logic [1:0] CMD_STEP = 2'd1;
    localparam logic [1:0] CMD_ZERO = 2'd2;

    // Register word indexes (paddr[3:2]).
    localparam logic [1:0] REG_GAIN_P    = 2'd0;
    localparam logic [1:0] REG_GAIN_I    = 2'd1;
    localparam logic [1:0] REG_GAIN_D    = 2'd2;
    localparam logic [1:0] REG_TOLERANCE = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_P_RST    = 16'd154;
    localparam logic [GAIN_W-1:0] GAIN_I_RST    = 16'd0;
    localparam logic [GAIN_W-1:0] GAIN_D_RST    = 16'd1;
    localparam logic [GAIN_W-1:0] TOLERANCE_RST = 16'd20;

    localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT = 8'sd100;
    localparam logic [DRIVE_W-1:0]        BRAKE_DUTY  = 8'd100;

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [GAIN_W-1:0] tolerance;
    } cfg_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_level;
        logic [DRIVE_W-1:0]        pwm_duty;
        logic                      brake;
        logic                      in_tolerance;
        logic signed [POS_W-1:0]   position;
    } result_t;

endpackage

>>> hw/rtl/pmpa_regs.sv
// APB register file holding the loop gains and the arrival tolerance.
`timescale 1ns / 1ps

module pmpa_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pmpa_pkg::ADDR_W-1:0]   paddr,
    input  logic [pmpa_pkg::DATA_W-1:0]   pwdata,
    output logic [pmpa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output pmpa_pkg::cfg_t                cfg
);
    import pmpa_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] word_idx;

    assign wr_en    = psel && penable && pwrite;
    assign word_idx = paddr[3:2];
    assign pready   = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p    <= GAIN_P_RST;
            cfg_reg.gain_i    <= GAIN_I_RST;
            cfg_reg.gain_d    <= GAIN_D_RST;
            cfg_reg.tolerance <= TOLERANCE_RST;
        end else if (wr_en) begin
            case (word_idx)
                REG_GAIN_P:    cfg_reg.gain_p    <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:    cfg_reg.gain_i    <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:    cfg_reg.gain_d    <= pwdata[GAIN_W-1:0];
                REG_TOLERANCE: cfg_reg.tolerance <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (word_idx)
            REG_GAIN_P:    prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_reg.gain_p};
            REG_GAIN_I:    prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_reg.gain_i};
            REG_GAIN_D:    prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_reg.gain_d};
            REG_TOLERANCE: prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_reg.tolerance};
            default:       prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/pmpa_core.sv
// Encoder count and PID update: loop state plus the per-item datapath.
`timescale 1ns / 1ps

module pmpa_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 step_en,
    input  logic [1:0]                           command,
    input  logic signed [pmpa_pkg::TARGET_W-1:0] target,
    input  pmpa_pkg::cfg_t                       cfg,
    output pmpa_pkg::result_t                    result
);
    import pmpa_pkg::*;

    localparam int ACC_W = 52;
    localparam int QUO_W = ACC_W - 8;
    localparam logic signed [QUO_W-1:0] QUO_HI = QUO_W'(DRIVE_LIMIT);
    localparam logic signed [QUO_W-1:0] QUO_LO = -QUO_W'(DRIVE_LIMIT);

    logic signed [POS_W-1:0]   pos_reg, pos_next;
    logic signed [POS_W-1:0]   esum_reg, esum_next;
    logic signed [POS_W-1:0]   prev_reg, prev_next;
    logic                      dir_reg, dir_next;
    logic signed [DRIVE_W-1:0] drive_reg, drive_next;
    logic                      intol_reg, intol_next;

    logic signed [POS_W:0]     diff, err33, sum33, dterm, tol33;
    logic signed [POS_W-1:0]   err, sum_sat;
    logic                      in_window;
    logic signed [48:0]        prod_p, prod_i;
    logic signed [49:0]        prod_d;
    logic signed [ACC_W-1:0]   acc;
    logic signed [QUO_W-1:0]   quo;
    logic signed [DRIVE_W-1:0] u;
    logic signed [DRIVE_W-1:0] drive_mag;

    // Error against the current count, saturated to 32 bits.
    always_comb begin
        diff  = {{(POS_W+1-TARGET_W){target[TARGET_W-1]}}, target} - {pos_reg[POS_W-1], pos_reg};
        if (diff[POS_W] != diff[POS_W-1]) begin
            err = diff[POS_W] ? POS_MIN : POS_MAX;
        end else begin
            err = diff[POS_W-1:0];
        end
        err33     = {err[POS_W-1], err};
        tol33     = {{(POS_W+1-GAIN_W){1'b0}}, cfg.tolerance};
        in_window = (err33 <= tol33) && (err33 >= -tol33);

        sum33 = {esum_reg[POS_W-1], esum_reg} + err33;
        if (sum33[POS_W] != sum33[POS_W-1]) begin
            sum_sat = sum33[POS_W] ? POS_MIN : POS_MAX;
        end else begin
            sum_sat = sum33[POS_W-1:0];
        end
        dterm = err33 - {prev_reg[POS_W-1], prev_reg};

        // Three independent multiplies with unsigned 8.8 gains.
        prod_p = $signed({1'b0, cfg.gain_p}) * err;
        prod_i = $signed({1'b0, cfg.gain_i}) * sum_sat;
        prod_d = $signed({1'b0, cfg.gain_d}) * dterm;
        acc    = {{(ACC_W-49){prod_p[48]}}, prod_p}
               + {{(ACC_W-49){prod_i[48]}}, prod_i}
               + {{(ACC_W-50){prod_d[49]}}, prod_d};

        // Divide by 256 rounding toward zero: floor, then bump negatives with a fraction.
        quo = acc[ACC_W-1:8] + QUO_W'(acc[ACC_W-1] && (acc[7:0] != 8'd0));
        if (quo > QUO_HI) begin
            u = DRIVE_LIMIT;
        end else if (quo < QUO_LO) begin
            u = -DRIVE_LIMIT;
        end else begin
            u = quo[DRIVE_W-1:0];
        end
    end

    always_comb begin
        pos_next   = pos_reg;
        esum_next  = esum_reg;
        prev_next  = prev_reg;
        dir_next   = dir_reg;
        drive_next = drive_reg;
        intol_next = intol_reg;
        case (command)
            CMD_EDGE: begin
                if (!dir_reg && (pos_reg != POS_MAX)) begin
                    pos_next = pos_reg + 32'sd1;
                end else if (dir_reg && (pos_reg != POS_MIN)) begin
                    pos_next = pos_reg - 32'sd1;
                end
            end
            CMD_STEP: begin
                if (in_window) begin
                    drive_next = '0;
                    intol_next = 1'b1;
                end else begin
                    esum_next  = sum_sat;
                    prev_next  = err;
                    drive_next = u;
                    intol_next = 1'b0;
                    if (u > 0) begin
                        dir_next = 1'b0;
                    end else if (u < 0) begin
                        dir_next = 1'b1;
                    end
                end
            end
            CMD_ZERO: pos_next = '0;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            esum_reg  <= '0;
            prev_reg  <= '0;
            dir_reg   <= 1'b0;
            drive_reg <= '0;
            intol_reg <= 1'b0;
        end else if (step_en) begin
            pos_reg   <= pos_next;
            esum_reg  <= esum_next;
            prev_reg  <= prev_next;
            dir_reg   <= dir_next;
            drive_reg <= drive_next;
            intol_reg <= intol_next;
        end
    end

    // The result reports the state as this item leaves it.
    always_comb begin
        drive_mag = drive_next[DRIVE_W-1] ? -drive_next : drive_next;
        result.drive_level  = drive_next;
        result.brake        = (drive_next == '0);
        result.pwm_duty     = result.brake ? BRAKE_DUTY : {drive_mag[DRIVE_W-2:0], 1'b0};
        result.in_tolerance = intol_next;
        result.position     = pos_next;
    end

endmodule

>>> hw/rtl/pid_motor_position_axis.sv
// Top level of the motor position axis: item registers, PID core and APB registers.
//
// Usage:
//   Items enter on the s_ channel (valid/ready): s_command selects an encoder
//   edge, a control step or a count zeroing; s_target_position is used by
//   control steps only. Every item yields exactly one result item on the m_
//   channel carrying drive level, PWM duty, brake, in-tolerance and position.
//   Gains and tolerance are written through the APB port while the block is
//   idle; pready is always high and reads return the stored values.
//   An accepted item waits in the input register, then the PID datapath
//   (three parallel multiplies and a sum) settles into the result register,
//   which raises m_valid, as soon as that register is free to take it.
//   One item is accepted per cycle while m_ready stays high.
//   When the receiver stalls, the result register holds its item and the
//   input register takes one more; s_ready then drops until m_ready returns.
//   Reset (aresetn low, synchronous) clears the count, the loop state and
//   both valid flags, and restores the reset gains and tolerance.
`timescale 1ns / 1ps
`include "pid_motor_position_axis_defines.svh"

module pid_motor_position_axis (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_command,
    input  logic signed [pmpa_pkg::TARGET_W-1:0] s_target_position,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pmpa_pkg::DRIVE_W-1:0]  m_drive_level,
    output logic [pmpa_pkg::DRIVE_W-1:0]         m_pwm_duty,
    output logic                                 m_brake,
    output logic                                 m_in_tolerance,
    output logic signed [pmpa_pkg::POS_W-1:0]    m_position,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pmpa_pkg::ADDR_W-1:0]          paddr,
    input  logic [pmpa_pkg::DATA_W-1:0]          pwdata,
    output logic [pmpa_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);
    import pmpa_pkg::*;

    cfg_t                       cfg;
    result_t                    core_result;
    result_t                    out_reg;
    logic                       out_vld_reg;
    logic                       in_vld_reg;
    logic [1:0]                 in_cmd_reg;
    logic signed [TARGET_W-1:0] in_target_reg;
    logic                       advance;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg    <= s_command;
            in_target_reg <= s_target_position;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    pmpa_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pmpa_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .command (in_cmd_reg),
        .target  (in_target_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    assign m_valid        = out_vld_reg;
    assign m_drive_level  = out_reg.drive_level;
    assign m_pwm_duty     = out_reg.pwm_duty;
    assign m_brake        = out_reg.brake;
    assign m_in_tolerance = out_reg.in_tolerance;
    assign m_position     = out_reg.position;

    `PMPA_ASSERT_NOW(a_brake_iff_zero, out_vld_reg, out_reg.brake == (out_reg.drive_level == '0), "brake disagrees with drive level")
    `PMPA_ASSERT_NOW(a_tol_brakes, out_vld_reg && out_reg.in_tolerance, out_reg.brake && (out_reg.pwm_duty == BRAKE_DUTY), "in-tolerance result is not braking")
    `PMPA_ASSERT_NOW(a_drive_range, out_vld_reg, (out_reg.drive_level <= DRIVE_LIMIT) && (out_reg.drive_level >= -DRIVE_LIMIT), "drive level outside limit")
    `PMPA_ASSERT_NEXT(a_stall_holds_item, in_vld_reg && !advance, in_vld_reg && out_vld_reg, "stalled item lost from input register")

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench of the motor position axis: encoder count, PID step and APB gains.
`timescale 1ns / 1ps

module testbench;
    import pmpa_pkg::*;

    // The command field has one code that the block must ignore.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [TARGET_W-1:0] TARGET_MAX = 17'sh0FFFF;
    localparam logic signed [TARGET_W-1:0] TARGET_MIN = 17'sh10000;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [1:0]                 s_command;
    logic signed [TARGET_W-1:0] s_target_position;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [DRIVE_W-1:0]  m_drive_level;
    logic [DRIVE_W-1:0]         m_pwm_duty;
    logic                       m_brake;
    logic                       m_in_tolerance;
    logic signed [POS_W-1:0]    m_position;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    // Predicted state of the axis and its register copy.
    cfg_t                      cfg;
    int                        pos_count;
    int                        err_sum;
    int                        prev_err;
    logic                      dir_down;
    logic signed [DRIVE_W-1:0] drive_held;
    logic                      tol_held;

    result_t pending_results[$];
    result_t want;
    int      failures = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    int      hold_left = 0;

    pid_motor_position_axis uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_target_position (s_target_position),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_drive_level     (m_drive_level),
        .m_pwm_duty        (m_pwm_duty),
        .m_brake           (m_brake),
        .m_in_tolerance    (m_in_tolerance),
        .m_position        (m_position),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int sat32(longint v);
        if (v > longint'(POS_MAX)) return POS_MAX;
        if (v < longint'(POS_MIN)) return POS_MIN;
        return int'(v);
    endfunction

    // Applies one item to the predicted state and returns the result it causes.
    function automatic result_t axis_advance(logic [1:0] cmd, logic signed [TARGET_W-1:0] tgt);
        longint  err;
        longint  mag;
        longint  acc;
        longint  u;
        int      level;
        result_t r;
        case (cmd)
            CMD_EDGE: pos_count = sat32(longint'(pos_count) + (dir_down ? -64'sd1 : 64'sd1));
            CMD_STEP: begin
                err = longint'(sat32(longint'(tgt) - longint'(pos_count)));
                mag = (err < 0) ? -err : err;
                if (mag <= longint'(cfg.tolerance)) begin
                    drive_held = '0;
                    tol_held   = 1'b1;
                end else begin
                    err_sum = sat32(longint'(err_sum) + err);
                    acc = longint'(cfg.gain_p) * err
                        + longint'(cfg.gain_i) * longint'(err_sum)
                        + longint'(cfg.gain_d) * (err - longint'(prev_err));
                    // Signed division truncates toward zero, as the hardware must.
                    u = acc / 256;
                    if (u > longint'(DRIVE_LIMIT)) u = longint'(DRIVE_LIMIT);
                    if (u < -longint'(DRIVE_LIMIT)) u = -longint'(DRIVE_LIMIT);
                    prev_err = int'(err);
                    if (u > 0) dir_down = 1'b0;
                    else if (u < 0) dir_down = 1'b1;
                    drive_held = u[DRIVE_W-1:0];
                    tol_held   = 1'b0;
                end
            end
            CMD_ZERO: pos_count = 0;
            default: ;
        endcase
        level = int'(drive_held);
        r.drive_level  = drive_held;
        if (level > 0) r.pwm_duty = DRIVE_W'(2 * level);
        else if (level < 0) r.pwm_duty = DRIVE_W'(-2 * level);
        else r.pwm_duty = BRAKE_DUTY;
        r.brake        = (level == 0);
        r.in_tolerance = tol_held;
        r.position     = pos_count;
        return r;
    endfunction

    function automatic logic signed [TARGET_W-1:0] near_target(int offset);
        return TARGET_W'(pos_count + offset);
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(3))
            0: return GAIN_W'($urandom_range(0, 400));
            1: return GAIN_W'($urandom_range(0, 4095));
            2: return GAIN_W'($urandom_range(0, 65535));
            default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic model_reset();
        cfg.gain_p    = GAIN_P_RST;
        cfg.gain_i    = GAIN_I_RST;
        cfg.gain_d    = GAIN_D_RST;
        cfg.tolerance = TOLERANCE_RST;
        pos_count  = 0;
        err_sum    = 0;
        prev_err   = 0;
        dir_down   = 1'b0;
        drive_held = '0;
        tol_held   = 1'b0;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 80; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 80; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
        endcase
    endtask

    // Offers one item and records its expected result once it is accepted.
    task automatic send_item(logic [1:0] cmd, logic signed [TARGET_W-1:0] tgt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_command         <= cmd;
        s_target_position <= tgt;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(axis_advance(cmd, tgt));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(logic [1:0] index, logic [GAIN_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_GAIN_P: cfg.gain_p = value;
            REG_GAIN_I: cfg.gain_i = value;
            REG_GAIN_D: cfg.gain_d = value;
            REG_TOLERANCE: cfg.tolerance = value;
            default: ;
        endcase
    endtask

    task automatic load_config(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                               logic [GAIN_W-1:0] kd, logic [GAIN_W-1:0] tol);
        write_register(REG_GAIN_P, kp);
        write_register(REG_GAIN_I, ki);
        write_register(REG_GAIN_D, kd);
        write_register(REG_TOLERANCE, tol);
    endtask

    // Every command with the reset gains, including the tolerance boundary.
    task automatic test_reset_values();
        send_item(CMD_EDGE, 0);
        send_item(CMD_UNUSED, -1);
        send_item(CMD_ZERO, TARGET_MAX);
        send_item(CMD_STEP, 0);
        send_item(CMD_STEP, 20);
        send_item(CMD_STEP, -20);
        send_item(CMD_STEP, 21);
        repeat (3) send_item(CMD_EDGE, TARGET_MIN);
        send_item(CMD_STEP, -21);
        repeat (3) send_item(CMD_EDGE, 0);
        send_item(CMD_STEP, TARGET_MAX);
        send_item(CMD_STEP, TARGET_MIN);
        repeat (2) send_item(CMD_EDGE, 0);
        send_item(CMD_ZERO, 0);
        send_item(CMD_EDGE, 0);
    endtask

    // Largest gains, zero tolerance, outputs that truncate to zero, widest tolerance.
    task automatic test_gain_extremes();
        drain_results();
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_item(CMD_STEP, near_target(1));
        send_item(CMD_STEP, near_target(-1));
        send_item(CMD_STEP, near_target(0));
        repeat (2) send_item(CMD_EDGE, 0);
        drain_results();
        load_config(16'd1, 16'd0, 16'd0, 16'd0);
        send_item(CMD_STEP, near_target(255));
        send_item(CMD_EDGE, 0);
        send_item(CMD_STEP, near_target(-255));
        send_item(CMD_STEP, near_target(256));
        send_item(CMD_EDGE, 0);
        send_item(CMD_STEP, near_target(-257));
        repeat (2) send_item(CMD_EDGE, 0);
        drain_results();
        load_config(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, 16'hFFFF);
        send_item(CMD_ZERO, 0);
        send_item(CMD_STEP, TARGET_MAX);
        send_item(CMD_STEP, TARGET_MIN);
        send_item(CMD_EDGE, 0);
    endtask

    // With only an integral gain the error sum builds up, then reverses sign,
    // so the drive follows the accumulated error rather than the latest one.
    task automatic test_error_sum_saturation();
        drain_results();
        set_idling(0);
        load_config(16'd0, 16'd1, 16'd0, 16'd0);
        send_item(CMD_ZERO, 0);
        repeat (8) send_item(CMD_STEP, TARGET_MAX);
        repeat (24) send_item(CMD_STEP, -65535);
        repeat (8) send_item(CMD_STEP, TARGET_MAX);
    endtask

    // The receiver holds off while items keep coming, so the input must stall.
    task automatic test_receiver_holdoff();
        drain_results();
        load_config(GAIN_P_RST, 16'd3, 16'd40, 16'd5);
        set_idling(0);
        hold_left = 300;
        for (int n = 0; n < 40; n++) begin
            if (n % 3 == 0) send_item(CMD_STEP, near_target($urandom_range(0, 400) - 200));
            else send_item(CMD_EDGE, 0);
        end
    endtask

    task automatic test_random_phases();
        int                         pick;
        int                         offset;
        logic [1:0]                 cmd;
        logic signed [TARGET_W-1:0] tgt;
        for (int ph = 0; ph < 8; ph++) begin
            drain_results();
            if (ph == 0) load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
            else if (ph == 1) load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
            else load_config(random_gain(), random_gain(), random_gain(),
                             GAIN_W'($urandom_range(0, 120)));
            set_idling(ph % 4);
            for (int n = 0; n < 225; n++) begin
                pick = $urandom_range(99);
                if (pick < 40) cmd = CMD_EDGE;
                else if (pick < 80) cmd = CMD_STEP;
                else if (pick < 93) cmd = CMD_ZERO;
                else cmd = CMD_UNUSED;
                case ($urandom_range(2))
                    0: tgt = TARGET_W'($urandom_range(0, 131071));
                    1: tgt = near_target($urandom_range(0, 600) - 300);
                    default: begin
                        // Just inside, on, or just outside the tolerance window.
                        offset = cfg.tolerance + $urandom_range(0, 2) - 1;
                        tgt = near_target($urandom_range(1) ? offset : -offset);
                    end
                endcase
                send_item(cmd, tgt);
            end
        end
    endtask

    task automatic check_field(string what, logic signed [63:0] want_v,
                               logic signed [63:0] got_v);
        if (got_v !== want_v) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                failures++;
                $display("%0t: result item with none expected, expected nothing, got position %0d",
                         $time, m_position);
            end else begin
                want = pending_results.pop_front();
                check_field("drive_level", 64'($signed(want.drive_level)), 64'(m_drive_level));
                check_field("pwm_duty", 64'(want.pwm_duty), 64'(m_pwm_duty));
                check_field("brake", 64'(want.brake), 64'(m_brake));
                check_field("in_tolerance", 64'(want.in_tolerance), 64'(m_in_tolerance));
                check_field("position", 64'($signed(want.position)), 64'(m_position));
            end
        end
    end

    initial begin
        aresetn           <= 1'b0;
        s_valid           <= 1'b0;
        s_command         <= CMD_EDGE;
        s_target_position <= '0;
        m_ready           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        model_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_gain_extremes();
        test_error_sum_saturation();
        test_receiver_holdoff();
        test_random_phases();

        drain_results();
        repeat (8) @(posedge aclk);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/pmpa_pkg.sv
hw/rtl/pmpa_regs.sv
hw/rtl/pmpa_core.sv
hw/rtl/pid_motor_position_axis.sv
tb/sv/testbench.sv
